[rtl/mcbsm_pkg.sv]
`default_nettype none
package mcbsm_pkg;

  // address decode
  localparam logic [15:0] ADDR_MASK   = 16'hE001;
  localparam logic [15:0] ADDR_OUTER  = 16'h6000;
  localparam logic [15:0] ADDR_SELECT = 16'h8000;
  localparam logic [15:0] ADDR_INDEX  = 16'h8001;
  localparam logic [15:0] ADDR_LOCK   = 16'hA001;

  // select/control bits
  localparam int SEL_CHR_INV  = 7;
  localparam int SEL_PRG_SWAP = 6;
  localparam int UNLOCK_BIT   = 7;

  // widths
  localparam int CHR_W  = 13;
  localparam int PRG_W  = 8;
  localparam int CNT_W  = 9;

  // reset values
  localparam logic [CNT_W-1:0] PRG_COUNT_RST = 9'd32;
  localparam logic [PRG_W-1:0] PRG2_RST = 8'(PRG_COUNT_RST - 9'd2);
  localparam logic [PRG_W-1:0] PRG3_RST = 8'(PRG_COUNT_RST - 9'd1);

  // register contents that feed the bank computation
  typedef struct packed {
    logic [7:0][7:0] bank;
    logic [7:0]      select;
    logic [3:0][7:0] outer;
  } state_t;

  // current bank mapping
  typedef struct packed {
    logic [7:0][CHR_W-1:0] chr;
    logic [3:0][PRG_W-1:0] prg;
  } map_t;

endpackage
`default_nettype wire

[rtl/mcbsm_regs.sv]
`default_nettype none
module mcbsm_regs (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [15:0]          address,
  input  wire logic [7:0]           data,
  output mcbsm_pkg::state_t         st_nxt,
  output logic                      remap
);

  mcbsm_pkg::state_t st_r;
  logic              unlock_r, unlock_nxt;
  logic [1:0]        wcnt_r, wcnt_nxt;
  logic [15:0]       addr_cls;

  assign addr_cls = address & mcbsm_pkg::ADDR_MASK;

  // next register contents for this request
  always_comb begin
    st_nxt     = st_r;
    unlock_nxt = unlock_r;
    wcnt_nxt   = wcnt_r;
    remap      = 1'b0;
    unique case (addr_cls)
      mcbsm_pkg::ADDR_OUTER: begin
        if (unlock_r) begin
          st_nxt.outer[wcnt_r] = data;
          wcnt_nxt             = wcnt_r + 2'd1;
          remap                = (wcnt_r == 2'd3);
        end
      end
      mcbsm_pkg::ADDR_SELECT: begin
        st_nxt.select = data;
        remap         = 1'b1;
      end
      mcbsm_pkg::ADDR_INDEX: begin
        st_nxt.bank[st_r.select[2:0]] = data;
        remap                         = 1'b1;
      end
      mcbsm_pkg::ADDR_LOCK: begin
        if (data[mcbsm_pkg::UNLOCK_BIT]) begin
          unlock_nxt = 1'b1;
          wcnt_nxt   = 2'd0;
        end else begin
          unlock_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // register update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '0;
      unlock_r <= 1'b0;
      wcnt_r   <= 2'd0;
    end else if (wr_en) begin
      st_r     <= st_nxt;
      unlock_r <= unlock_nxt;
      wcnt_r   <= wcnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/mcbsm_remap.sv]
`default_nettype none
module mcbsm_remap (
  input  wire mcbsm_pkg::state_t                  st,
  input  wire logic [mcbsm_pkg::CNT_W-1:0]        prg_count,
  output mcbsm_pkg::map_t                         map
);

  logic [11:0]                 hi, keep;
  logic [5:0][11:0]            c;
  logic [7:0][mcbsm_pkg::CHR_W-1:0] list;
  logic [7:0]                  m8, p0, p1, p2, p3;
  logic [mcbsm_pkg::CNT_W-1:0] lim;

  // chr values combined with the outer bank
  assign hi   = {st.outer[1], 4'h0};
  assign keep = {st.outer[2], 4'hF};

  // prg banks
  assign m8  = {2'b00, st.outer[3][5:0] ^ 6'h3F};
  assign p0  = (st.bank[6] & m8) | st.outer[1];
  assign p1  = (st.bank[7] & m8) | st.outer[1];
  assign p3  = m8 | st.outer[1];
  assign lim = prg_count - 9'd1;
  assign p2  = p3 & lim[7:0];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      c[i] = ({4'h0, st.bank[i]} | hi) & keep;
    end
    list[0] = {1'b0, c[0]};
    list[1] = {1'b0, c[0]} + 13'd1;
    list[2] = {1'b0, c[1]};
    list[3] = {1'b0, c[1]} + 13'd1;
    list[4] = {1'b0, c[2]};
    list[5] = {1'b0, c[3]};
    list[6] = {1'b0, c[4]};
    list[7] = {1'b0, c[5]};
    // inversion swaps the two halves of the pattern space
    for (int j = 0; j < 8; j++) begin
      map.chr[j] = st.select[mcbsm_pkg::SEL_CHR_INV] ? list[j ^ 4] : list[j];
    end
    // prg swap trades the first and third slots
    map.prg[0] = st.select[mcbsm_pkg::SEL_PRG_SWAP] ? p2 : p0;
    map.prg[1] = p1;
    map.prg[2] = st.select[mcbsm_pkg::SEL_PRG_SWAP] ? p0 : p2;
    map.prg[3] = p3;
  end

endmodule
`default_nettype wire

[rtl/multicart_bank_switch_mapper.sv]
// path: an accepted write passes the input register, then the result register
// throughput: one write request per cycle unless stalled; the register update and bank
//   computation sit in one stage between the input and the result register
// reset: rst_n synchronous, active low; chr banks 0, prg banks 0, 1, 30, 31,
//   bank count 32, outer registers locked
`default_nettype none
module multicart_bank_switch_mapper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [12:0]      out_chr_bank_0,
  output logic [12:0]      out_chr_bank_1,
  output logic [12:0]      out_chr_bank_2,
  output logic [12:0]      out_chr_bank_3,
  output logic [12:0]      out_chr_bank_4,
  output logic [12:0]      out_chr_bank_5,
  output logic [12:0]      out_chr_bank_6,
  output logic [12:0]      out_chr_bank_7,
  output logic [7:0]       out_prg_bank_0,
  output logic [7:0]       out_prg_bank_1,
  output logic [7:0]       out_prg_bank_2,
  output logic [7:0]       out_prg_bank_3,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data
);

  logic                        s1_valid_r;
  logic [15:0]                 s1_addr_r;
  logic [7:0]                  s1_data_r;
  logic                        out_valid_r;
  logic                        adv;
  logic                        remap;
  logic [mcbsm_pkg::CNT_W-1:0] prg_count_r;
  mcbsm_pkg::state_t           st_nxt;
  mcbsm_pkg::map_t             map_calc, map_r;

  // stage 1 moves on whenever the result register is free
  assign adv       = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_addr_r <= in_address;
      s1_data_r <= in_data;
    end
  end

  // bank count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_count_r <= mcbsm_pkg::PRG_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      prg_count_r <= cfg_data;
    end
  end

  mcbsm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (adv),
    .address (s1_addr_r),
    .data    (s1_data_r),
    .st_nxt  (st_nxt),
    .remap   (remap)
  );

  mcbsm_remap u_remap (
    .st        (st_nxt),
    .prg_count (prg_count_r),
    .map       (map_calc)
  );

  // result register, which also holds the current mapping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      map_r.chr   <= '0;
      map_r.prg[0] <= 8'd0;
      map_r.prg[1] <= 8'd1;
      map_r.prg[2] <= mcbsm_pkg::PRG2_RST;
      map_r.prg[3] <= mcbsm_pkg::PRG3_RST;
    end else begin
      if (!(out_valid_r && out_stall)) begin
        out_valid_r <= s1_valid_r;
      end
      if (adv && remap) begin
        map_r <= map_calc;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_chr_bank_0 = map_r.chr[0];
  assign out_chr_bank_1 = map_r.chr[1];
  assign out_chr_bank_2 = map_r.chr[2];
  assign out_chr_bank_3 = map_r.chr[3];
  assign out_chr_bank_4 = map_r.chr[4];
  assign out_chr_bank_5 = map_r.chr[5];
  assign out_chr_bank_6 = map_r.chr[6];
  assign out_chr_bank_7 = map_r.chr[7];
  assign out_prg_bank_0 = map_r.prg[0];
  assign out_prg_bank_1 = map_r.prg[1];
  assign out_prg_bank_2 = map_r.prg[2];
  assign out_prg_bank_3 = map_r.prg[3];

`ifndef SYNTHESIS
  // a request leaving stage 1 always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("request lost between stage 1 and result register");

  // a lock/unlock request never changes the mapping
  a_lock_no_remap: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && ((s1_addr_r & mcbsm_pkg::ADDR_MASK) == mcbsm_pkg::ADDR_LOCK))
    |=> ($stable(map_r)))
    else $error("mapping changed on a lock request");

  // mapping only changes when a request advances
  a_map_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(map_r))
    else $error("mapping changed with no request");
`endif

endmodule
`default_nettype wire
